/* hdl/rv32ss_pkg.sv */
// Shared types and constants for the RV32I subset execute step.
// Opcode and funct codes, data memory geometry and the execute result struct.
// No dependencies.
package rv32ss_pkg;

  localparam int unsigned DMEM_BYTES = 65536;
  localparam int unsigned DMEM_AW    = $clog2(DMEM_BYTES);
  localparam int unsigned ROW_AW     = DMEM_AW - 2;
  localparam int unsigned DMEM_ROWS  = DMEM_BYTES / 4;
  localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(DMEM_ROWS - 1);

  localparam logic [31:0] OUT_PORT_ADDR = 32'h0000_5000;

  typedef enum logic [6:0] {
    OPC_LOAD   = 7'h03,
    OPC_OPIMM  = 7'h13,
    OPC_STORE  = 7'h23,
    OPC_OP     = 7'h33,
    OPC_BRANCH = 7'h63,
    OPC_JAL    = 7'h6F
  } opcode_t;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_BYTE = 3'd0;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  typedef struct packed {
    logic [31:0] npc;
    logic        wen;
    logic [31:0] wval;
    logic        load;
    logic        store_w;
    logic        store_b;
    logic [31:0] ea;
    logic        cvalid;
    logic [7:0]  cval;
    logic        halt;
  } exec_t;

endpackage

/* hdl/rv32ss_in_if.sv */
// Instruction channel: valid/ready handshake carrying one instruction word.
// No dependencies.
interface rv32ss_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

/* hdl/rv32ss_out_if.sv */
// Result channel: valid/ready handshake carrying one execute result item.
// No dependencies.
interface rv32ss_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        reg_write_enable;
  logic [4:0]  reg_write_index;
  logic [31:0] reg_write_value;
  logic        char_valid;
  logic [7:0]  char_value;
  logic        halted;

  modport source (output valid, output next_pc, output reg_write_enable,
                  output reg_write_index, output reg_write_value,
                  output char_valid, output char_value, output halted,
                  input ready);
  modport sink   (input valid, input next_pc, input reg_write_enable,
                  input reg_write_index, input reg_write_value,
                  input char_valid, input char_value, input halted,
                  output ready);
endinterface

/* hdl/rv32ss_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rv32ss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/rv32ss_exec.sv */
// Instruction decode, ALU, branch/jump target and effective address logic.
// Depends on rv32ss_pkg.
module rv32ss_exec (
  input  logic [31:0]        instr,
  input  logic [31:0]        pc,
  input  logic [31:0]        rs1_val,
  input  logic [31:0]        rs2_val,
  output rv32ss_pkg::exec_t  res
);

  always_comb begin
    logic [6:0]  opcode;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] opb;
    logic [4:0]  shamt;
    logic        is_op;
    logic        ok_base;
    logic        alt;
    logic        alu_ok;
    logic [31:0] alu_val;
    logic [31:0] pc4;
    logic        wen_raw;

    opcode = instr[6:0];
    f3     = instr[14:12];
    f7     = instr[31:25];
    rd     = instr[11:7];
    imm_i  = {{20{instr[31]}}, instr[31:20]};
    imm_s  = {{20{instr[31]}}, instr[31:25], instr[11:7]};
    imm_b  = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    imm_j  = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
    pc4    = pc + 32'd4;

    is_op   = (opcode == rv32ss_pkg::OPC_OP);
    opb     = is_op ? rs2_val : imm_i;
    shamt   = opb[4:0];
    ok_base = !is_op || (f7 == rv32ss_pkg::F7_BASE);
    alt     = is_op && (f7 == rv32ss_pkg::F7_ALT);

    alu_ok  = ok_base;
    alu_val = '0;
    case (f3)
      rv32ss_pkg::F3_ADD: begin
        alu_ok  = ok_base || alt;
        alu_val = alt ? (rs1_val - opb) : (rs1_val + opb);
      end
      rv32ss_pkg::F3_SLL:  alu_val = rs1_val << shamt;
      rv32ss_pkg::F3_SLT:  alu_val = {31'd0, $signed(rs1_val) < $signed(opb)};
      rv32ss_pkg::F3_SLTU: alu_val = {31'd0, rs1_val < opb};
      rv32ss_pkg::F3_XOR:  alu_val = rs1_val ^ opb;
      rv32ss_pkg::F3_SR: begin
        if (f7 == rv32ss_pkg::F7_BASE) begin
          alu_ok  = 1'b1;
          alu_val = rs1_val >> shamt;
        end else if (f7 == rv32ss_pkg::F7_ALT) begin
          alu_ok  = 1'b1;
          alu_val = 32'($signed(rs1_val) >>> shamt);
        end else begin
          alu_ok  = 1'b0;
        end
      end
      rv32ss_pkg::F3_OR:   alu_val = rs1_val | opb;
      rv32ss_pkg::F3_AND:  alu_val = rs1_val & opb;
      default:             alu_ok  = 1'b0;
    endcase

    wen_raw     = 1'b0;
    res         = '0;
    res.npc     = pc;
    res.ea      = rs1_val + imm_i;
    case (opcode)
      rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::OPC_OP: begin
        wen_raw  = alu_ok;
        res.wval = alu_val;
        res.npc  = pc4;
      end
      rv32ss_pkg::OPC_BRANCH: begin
        if (f3 == rv32ss_pkg::F3_BEQ) begin
          res.npc = (rs1_val == rs2_val) ? (pc + imm_b) : pc4;
        end else begin
          res.halt = 1'b1;
        end
      end
      rv32ss_pkg::OPC_JAL: begin
        wen_raw  = 1'b1;
        res.wval = pc4;
        res.npc  = pc + imm_j;
      end
      rv32ss_pkg::OPC_LOAD: begin
        if (f3 == rv32ss_pkg::F3_WORD) begin
          wen_raw  = 1'b1;
          res.load = 1'b1;
          res.npc  = pc4;
        end else begin
          res.halt = 1'b1;
        end
      end
      rv32ss_pkg::OPC_STORE: begin
        res.ea = rs1_val + imm_s;
        if (f3 == rv32ss_pkg::F3_WORD) begin
          res.store_w = 1'b1;
          res.npc     = pc4;
        end else if (f3 == rv32ss_pkg::F3_BYTE) begin
          if (rs1_val + imm_s == rv32ss_pkg::OUT_PORT_ADDR) begin
            res.cvalid = 1'b1;
            res.cval   = rs2_val[7:0];
          end else begin
            res.store_b = 1'b1;
          end
          res.npc = pc4;
        end else begin
          res.halt = 1'b1;
        end
      end
      default: res.halt = 1'b1;
    endcase

    res.wen = wen_raw && (rd != 5'd0);
    if (!res.wen) begin
      res.wval = '0;
    end
  end

endmodule

/* hdl/rv32i_subset_execute_step.sv */
// RV32I subset execute step: one instruction word in, one result item out.
// Channels: in_chan carries the instruction fetched at the current PC; out_chan
// carries next_pc, the register write, the character port byte and halted.
// An item moves on a rising edge with valid and ready both high.
// A result passes through the execute stage register and the output register;
// LW also holds the execute stage for the registered read of the data memory.
// Throughput: one instruction per cycle unless out_chan stalls or an LW waits.
// Registers sit in two 32x32 RAMs (one per read port) with per-entry valid
// bits; an entry never written reads as zero. The data memory is four byte
// banks of DMEM_BYTES/4 rows, so an unaligned word touches each bank once.
// Reset (rst_n low, synchronous) clears PC, valid bits and the pipeline, then
// a clearing pass zeroes the data memory one row per cycle: in_chan.ready stays
// low until the pass has cleared the last row.
// When out_chan stalls, one finished result waits in the output register and
// one more instruction is taken and held in the execute stage; further input
// waits until the output register drains.
// Depends on rv32ss_pkg, rv32ss_in_if, rv32ss_out_if, rv32ss_ram, rv32ss_exec.
module rv32i_subset_execute_step (
  input  logic                clk,
  input  logic                rst_n,
  rv32ss_in_if.sink           in_chan,
  rv32ss_out_if.source        out_chan
);

  localparam int unsigned ROW_AW  = rv32ss_pkg::ROW_AW;
  localparam int unsigned DMEM_AW = rv32ss_pkg::DMEM_AW;

  logic              clr_active_r, clr_active_nxt;
  logic [ROW_AW-1:0] clr_row_r, clr_row_nxt;
  logic              ex_valid_r, ex_valid_nxt;
  logic              ex_phase_r, ex_phase_nxt;
  logic [31:0]       ex_instr_r;
  logic [31:0]       pc_r, pc_nxt;
  logic [31:0]       rf_valid_r, rf_valid_nxt;
  logic              fwd_en_r;
  logic [4:0]        fwd_idx_r;
  logic [31:0]       fwd_val_r;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_next_pc_r;
  logic              out_wen_r;
  logic [4:0]        out_widx_r;
  logic [31:0]       out_wval_r;
  logic              out_cvalid_r;
  logic [7:0]        out_cval_r;
  logic              out_halt_r;

  logic              in_ready, in_fire, out_free, ex_done;
  logic [4:0]        rf_ra1, rf_ra2, ex_rs1, ex_rs2, rf_widx;
  logic [31:0]       rf_rd1, rf_rd2, ex_a, ex_b;
  logic              rf_we;
  logic [31:0]       rf_wdata, load_word;
  rv32ss_pkg::exec_t exec;

  logic [DMEM_AW-1:0] base;
  logic [1:0]         boff;
  logic [ROW_AW-1:0]  brow;
  logic [ROW_AW-1:0]  bank_rrow  [4];
  logic [ROW_AW-1:0]  bank_waddr [4];
  logic [7:0]         bank_wdata [4];
  logic [7:0]         bank_rdata [4];
  logic               bank_we    [4];

  // handshake
  assign out_free = !out_valid_r || out_chan.ready;
  assign ex_done  = ex_valid_r && out_free && (!exec.load || ex_phase_r);
  assign in_ready = !clr_active_r && (!ex_valid_r || ex_done);
  assign in_fire  = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  // register file: re-read held instruction's operands while it waits
  assign ex_rs1 = ex_instr_r[19:15];
  assign ex_rs2 = ex_instr_r[24:20];
  assign rf_ra1 = in_fire ? in_chan.instruction[19:15] : ex_rs1;
  assign rf_ra2 = in_fire ? in_chan.instruction[24:20] : ex_rs2;
  assign rf_widx = ex_instr_r[11:7];
  assign rf_we   = ex_done && exec.wen;
  assign rf_wdata = exec.load ? load_word : exec.wval;

  rv32ss_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_widx), .wdata(rf_wdata),
    .raddr(rf_ra1), .rdata(rf_rd1)
  );

  rv32ss_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_widx), .wdata(rf_wdata),
    .raddr(rf_ra2), .rdata(rf_rd2)
  );

  // write in the accept cycle is missed by the RAM read; bypass it
  assign ex_a = (fwd_en_r && fwd_idx_r == ex_rs1) ? fwd_val_r :
                (rf_valid_r[ex_rs1] ? rf_rd1 : 32'd0);
  assign ex_b = (fwd_en_r && fwd_idx_r == ex_rs2) ? fwd_val_r :
                (rf_valid_r[ex_rs2] ? rf_rd2 : 32'd0);

  rv32ss_exec u_exec (
    .instr(ex_instr_r), .pc(pc_r), .rs1_val(ex_a), .rs2_val(ex_b), .res(exec)
  );

  // data memory banks
  assign base = exec.ea[DMEM_AW-1:0];
  assign boff = base[1:0];
  assign brow = base[DMEM_AW-1:2];

  always_comb begin
    logic [1:0] k;
    for (int j = 0; j < 4; j++) begin
      k = 2'(j) - boff;
      bank_rrow[j] = brow + ROW_AW'(2'(j) < boff);
      if (clr_active_r) begin
        bank_waddr[j] = clr_row_r;
        bank_wdata[j] = 8'd0;
        bank_we[j]    = 1'b1;
      end else begin
        bank_waddr[j] = bank_rrow[j];
        bank_wdata[j] = ex_b[8*k +: 8];
        bank_we[j]    = ex_done && (exec.store_w || (exec.store_b && 2'(j) == boff));
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    rv32ss_ram #(.WIDTH(8), .DEPTH(rv32ss_pkg::DMEM_ROWS)) u_bank (
      .clk(clk), .we(bank_we[g]), .waddr(bank_waddr[g]), .wdata(bank_wdata[g]),
      .raddr(bank_rrow[g]), .rdata(bank_rdata[g])
    );
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      load_word[8*k +: 8] = bank_rdata[2'(k) + boff];
    end
  end

  // next state
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_row_nxt    = clr_row_r;
    if (clr_active_r) begin
      clr_row_nxt = clr_row_r + ROW_AW'(1);
      if (clr_row_r == rv32ss_pkg::ROW_LAST) begin
        clr_active_nxt = 1'b0;
      end
    end

    ex_valid_nxt = ex_valid_r;
    if (in_fire) begin
      ex_valid_nxt = 1'b1;
    end else if (ex_done) begin
      ex_valid_nxt = 1'b0;
    end

    ex_phase_nxt = ex_phase_r;
    if (ex_done) begin
      ex_phase_nxt = 1'b0;
    end else if (ex_valid_r && exec.load) begin
      ex_phase_nxt = 1'b1;
    end

    pc_nxt       = ex_done ? exec.npc : pc_r;
    rf_valid_nxt = rf_valid_r;
    if (rf_we) begin
      rf_valid_nxt[rf_widx] = 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (ex_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_row_r    <= '0;
      ex_valid_r   <= 1'b0;
      ex_phase_r   <= 1'b0;
      pc_r         <= '0;
      rf_valid_r   <= '0;
      fwd_en_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_row_r    <= clr_row_nxt;
      ex_valid_r   <= ex_valid_nxt;
      ex_phase_r   <= ex_phase_nxt;
      pc_r         <= pc_nxt;
      rf_valid_r   <= rf_valid_nxt;
      fwd_en_r     <= rf_we;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_instr_r <= in_chan.instruction;
    end
    fwd_idx_r <= rf_widx;
    fwd_val_r <= rf_wdata;
    if (ex_done) begin
      out_next_pc_r <= exec.npc;
      out_wen_r     <= exec.wen;
      out_widx_r    <= exec.wen ? rf_widx : 5'd0;
      out_wval_r    <= exec.wen ? rf_wdata : 32'd0;
      out_cvalid_r  <= exec.cvalid;
      out_cval_r    <= exec.cval;
      out_halt_r    <= exec.halt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.next_pc          = out_next_pc_r;
  assign out_chan.reg_write_enable = out_wen_r;
  assign out_chan.reg_write_index  = out_widx_r;
  assign out_chan.reg_write_value  = out_wval_r;
  assign out_chan.char_valid       = out_cvalid_r;
  assign out_chan.char_value       = out_cval_r;
  assign out_chan.halted           = out_halt_r;

  // checks
  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_chan.ready)
    else $error("input taken during memory clear");

  a_pc_matches_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_next_pc_r == pc_r))
    else $error("pc out of step with pending result");

  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (rf_widx != 5'd0))
    else $error("write to x0");

  a_phase_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    ex_phase_r |-> (ex_valid_r && exec.load))
    else $error("load phase without a load");

  a_load_waits_read: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_valid_r && exec.load && !ex_phase_r) |-> !ex_done)
    else $error("load finished before memory read");

endmodule

/* tb/sv/tb_rv32i_subset_execute_step.sv */
`timescale 1ns / 100ps
// Self-checking testbench for rv32i_subset_execute_step: instruction items in, retire items out.
// Predicts each retire item from a local copy of registers, PC and data memory.
// Depends on rv32ss_pkg, rv32ss_in_if, rv32ss_out_if and the DUT sources.
module tb_rv32i_subset_execute_step;

  localparam int ITEM_TARGET    = 1450;
  localparam int WATCHDOG_LIMIT = 4 * rv32ss_pkg::DMEM_ROWS;
  localparam int HOLD_CYCLES    = 300;
  localparam int DMEM_AW        = rv32ss_pkg::DMEM_AW;

  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_HALF = 3'd1;
  localparam logic [6:0] F7_BAD  = 7'h01;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        wen;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic        char_valid;
    logic [7:0]  char_value;
    logic        halted;
  } retire_t;

  logic clk = 1'b0;
  logic rst_n;

  rv32ss_in_if  in_ch ();
  rv32ss_out_if out_ch ();

  rv32i_subset_execute_step dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] arch_regs [32];
  logic [31:0] arch_pc;
  logic [7:0]  arch_mem [rv32ss_pkg::DMEM_BYTES];

  retire_t pending_retires [$];
  int      mismatch_count = 0;
  int      instr_sent = 0;
  int      idle_cycles = 0;
  int      rx_hold_cycles = 0;
  bit      tx_no_idle = 1'b0;
  bit      rx_no_idle = 1'b0;

  // ---------------------------------------------------------------- predictor
  function automatic logic [31:0] mem_read_word(input logic [31:0] ea);
    logic [DMEM_AW-1:0] ba;
    logic [31:0]        w;
    int                 k;
    ba = ea[DMEM_AW-1:0];
    for (k = 0; k < 4; k++) begin
      w[8*k +: 8] = arch_mem[ba];
      ba = ba + 1'b1;
    end
    return w;
  endfunction

  function automatic void mem_write_word(input logic [31:0] ea, input logic [31:0] w);
    logic [DMEM_AW-1:0] ba;
    int                 k;
    ba = ea[DMEM_AW-1:0];
    for (k = 0; k < 4; k++) begin
      arch_mem[ba] = w[8*k +: 8];
      ba = ba + 1'b1;
    end
  endfunction

  function automatic retire_t retire_instr(input logic [31:0] ins);
    retire_t     r;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a, b, pc, wval, ea;
    logic [31:0] imm_i, imm_s, imm_b, imm_j;
    logic        wen, halt;
    rd  = ins[11:7];
    rs1 = ins[19:15];
    rs2 = ins[24:20];
    f3  = ins[14:12];
    f7  = ins[31:25];
    a   = arch_regs[rs1];
    b   = arch_regs[rs2];
    pc  = arch_pc;
    imm_i = {{20{ins[31]}}, ins[31:20]};
    imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    r = '0;
    r.next_pc = pc + 32'd4;
    wen  = 1'b0;
    wval = '0;
    halt = 1'b0;
    case (ins[6:0])
      rv32ss_pkg::OPC_OPIMM: begin
        wen = 1'b1;
        case (f3)
          rv32ss_pkg::F3_ADD:  wval = a + imm_i;
          rv32ss_pkg::F3_SLL:  wval = a << imm_i[4:0];
          rv32ss_pkg::F3_SLT:  wval = {31'd0, $signed(a) < $signed(imm_i)};
          rv32ss_pkg::F3_SLTU: wval = {31'd0, a < imm_i};
          rv32ss_pkg::F3_XOR:  wval = a ^ imm_i;
          rv32ss_pkg::F3_SR: begin
            if (f7 == rv32ss_pkg::F7_BASE) wval = a >> imm_i[4:0];
            else if (f7 == rv32ss_pkg::F7_ALT) wval = $signed(a) >>> imm_i[4:0];
            else wen = 1'b0;
          end
          rv32ss_pkg::F3_OR:   wval = a | imm_i;
          default:             wval = a & imm_i;
        endcase
      end
      rv32ss_pkg::OPC_OP: begin
        wen = 1'b1;
        case ({f7, f3})
          {rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_ADD}:  wval = a + b;
          {rv32ss_pkg::F7_ALT,  rv32ss_pkg::F3_ADD}:  wval = a - b;
          {rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_SLL}:  wval = a << b[4:0];
          {rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_SLT}:  wval = {31'd0, $signed(a) < $signed(b)};
          {rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_SLTU}: wval = {31'd0, a < b};
          {rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_XOR}:  wval = a ^ b;
          {rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_SR}:   wval = a >> b[4:0];
          {rv32ss_pkg::F7_ALT,  rv32ss_pkg::F3_SR}:   wval = $signed(a) >>> b[4:0];
          {rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_OR}:   wval = a | b;
          {rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_AND}:  wval = a & b;
          default:                                    wen = 1'b0;
        endcase
      end
      rv32ss_pkg::OPC_BRANCH: begin
        if (f3 != rv32ss_pkg::F3_BEQ) halt = 1'b1;
        else if (a == b) r.next_pc = pc + imm_b;
      end
      rv32ss_pkg::OPC_JAL: begin
        wen = 1'b1;
        wval = pc + 32'd4;
        r.next_pc = pc + imm_j;
      end
      rv32ss_pkg::OPC_LOAD: begin
        if (f3 == rv32ss_pkg::F3_WORD) begin
          wen = 1'b1;
          wval = mem_read_word(a + imm_i);
        end else begin
          halt = 1'b1;
        end
      end
      rv32ss_pkg::OPC_STORE: begin
        ea = a + imm_s;
        if (f3 == rv32ss_pkg::F3_WORD) begin
          mem_write_word(ea, b);
        end else if (f3 == rv32ss_pkg::F3_BYTE) begin
          if (ea == rv32ss_pkg::OUT_PORT_ADDR) begin
            r.char_valid = 1'b1;
            r.char_value = b[7:0];
          end else begin
            arch_mem[ea[DMEM_AW-1:0]] = b[7:0];
          end
        end else begin
          halt = 1'b1;
        end
      end
      default: halt = 1'b1;
    endcase
    if (halt) r.next_pc = pc;
    r.halted = halt;
    if (wen && rd != 5'd0) begin
      arch_regs[rd] = wval;
      r.wen  = 1'b1;
      r.widx = rd;
      r.wval = wval;
    end
    arch_pc = r.next_pc;
    return r;
  endfunction

  // ---------------------------------------------------------------- encoders
  function automatic logic [31:0] enc_i(input rv32ss_pkg::opcode_t op,
                                        input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, rv32ss_pkg::OPC_OP};
  endfunction

  function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], rv32ss_pkg::OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [12:0] imm);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rv32ss_pkg::OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rv32ss_pkg::OPC_JAL};
  endfunction

  function automatic logic [6:0] pick_f7();
    int p;
    p = $urandom_range(0, 9);
    if (p < 4) return rv32ss_pkg::F7_BASE;
    if (p < 8) return rv32ss_pkg::F7_ALT;
    return 7'($urandom);
  endfunction

  function automatic logic [31:0] random_instr();
    int          sel;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  op7;
    logic [11:0] imm;
    sel = $urandom_range(0, 99);
    rd  = 5'($urandom);
    rs1 = 5'($urandom);
    rs2 = 5'($urandom);
    f3  = 3'($urandom);
    imm = 12'($urandom);
    if (sel < 35) begin
      if (f3 == rv32ss_pkg::F3_SR) imm[11:5] = pick_f7();
      return enc_i(rv32ss_pkg::OPC_OPIMM, f3, rd, rs1, imm);
    end
    if (sel < 60) return enc_r(pick_f7(), f3, rd, rs1, rs2);
    if (sel < 68) begin
      if ($urandom_range(0, 1)) rs2 = rs1;
      return enc_b(rv32ss_pkg::F3_BEQ, rs1, rs2, 13'($urandom));
    end
    if (sel < 73) return enc_j(rd, 21'($urandom));
    if (sel < 81) return enc_i(rv32ss_pkg::OPC_LOAD, rv32ss_pkg::F3_WORD, rd, rs1, imm);
    if (sel < 88) begin
      return enc_s($urandom_range(0, 1) ? rv32ss_pkg::F3_WORD : rv32ss_pkg::F3_BYTE,
                   rs1, rs2, imm);
    end
    if (sel < 95) begin
      case ($urandom_range(0, 3))
        0: begin
          while (f3 == rv32ss_pkg::F3_BEQ) f3 = 3'($urandom);
          return enc_b(f3, rs1, rs2, 13'($urandom));
        end
        1: begin
          while (f3 == rv32ss_pkg::F3_WORD) f3 = 3'($urandom);
          return enc_i(rv32ss_pkg::OPC_LOAD, f3, rd, rs1, imm);
        end
        2: begin
          while (f3 == rv32ss_pkg::F3_WORD || f3 == rv32ss_pkg::F3_BYTE) f3 = 3'($urandom);
          return enc_s(f3, rs1, rs2, imm);
        end
        default: begin
          do op7 = 7'($urandom);
          while (op7 == rv32ss_pkg::OPC_LOAD || op7 == rv32ss_pkg::OPC_OPIMM ||
                 op7 == rv32ss_pkg::OPC_STORE || op7 == rv32ss_pkg::OPC_OP ||
                 op7 == rv32ss_pkg::OPC_BRANCH || op7 == rv32ss_pkg::OPC_JAL);
          return {25'($urandom), op7};
        end
      endcase
    end
    return $urandom;
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic send_instr(input logic [31:0] word);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.instruction <= word;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_retires.push_back(retire_instr(word));
    instr_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_retires.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_reset();
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (arch_mem[i]) arch_mem[i] = '0;
    arch_pc = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  endtask

  // store then load nearby, so loads see written data
  task automatic run_store_load();
    logic [4:0]  rb;
    logic [11:0] simm;
    int          delta;
    rb    = 5'($urandom_range(1, 31));
    simm  = 12'($urandom);
    delta = $urandom_range(0, 6) - 3;
    send_instr(enc_s($urandom_range(0, 1) ? rv32ss_pkg::F3_WORD : rv32ss_pkg::F3_BYTE,
                     rb, 5'($urandom), simm));
    send_instr(enc_i(rv32ss_pkg::OPC_LOAD, rv32ss_pkg::F3_WORD, 5'($urandom), rb,
                     simm + 12'(delta)));
  endtask

  // build a base near the character port, optionally with nonzero upper half
  task automatic run_port_write();
    logic [4:0] rb, rc;
    int         off;
    rb  = 5'($urandom_range(1, 31));
    rc  = (rb == 5'd31) ? 5'd1 : rb + 5'd1;
    off = $urandom_range(0, 32) - 16;
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_ADD, rb, 5'd0, 12'h500));
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_SLL, rb, rb, 12'd4));
    if ($urandom_range(0, 3) == 0) begin
      send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_ADD, rc, 5'd0, 12'hFFF));
      send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_SLL, rc, rc, 12'd16));
      send_instr(enc_r(rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_ADD, rb, rb, rc));
    end
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_ADD, rb, rb, 12'(-off)));
    send_instr(enc_s($urandom_range(0, 4) == 0 ? rv32ss_pkg::F3_WORD : rv32ss_pkg::F3_BYTE,
                     rb, 5'($urandom), 12'(off)));
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_alu_immediate();
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_ADD,  5'd1,  5'd0, 12'hFFF));
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_ADD,  5'd2,  5'd0, 12'h7FF));
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_SLT,  5'd3,  5'd1, 12'h000));
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_SLTU, 5'd4,  5'd0, 12'hFFF));
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_XOR,  5'd5,  5'd1, 12'h800));
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_OR,   5'd6,  5'd0, 12'h800));
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_AND,  5'd7,  5'd1, 12'h0F0));
    // upper immediate bits of SLLI are ignored
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_SLL,  5'd8,  5'd1,
                     {7'h7F, 5'd31}));
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_SR,   5'd9,  5'd8,
                     {rv32ss_pkg::F7_BASE, 5'd31}));
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_SR,   5'd10, 5'd8,
                     {rv32ss_pkg::F7_ALT, 5'd31}));
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_SR,   5'd11, 5'd1,
                     {F7_BAD, 5'd4}));
  endtask

  task automatic test_alu_register();
    send_instr(enc_r(rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_ADD,  5'd12, 5'd1, 5'd2));
    send_instr(enc_r(rv32ss_pkg::F7_ALT,  rv32ss_pkg::F3_ADD,  5'd13, 5'd0, 5'd1));
    send_instr(enc_r(rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_SLL,  5'd14, 5'd1, 5'd5));
    send_instr(enc_r(rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_SLT,  5'd15, 5'd8, 5'd0));
    send_instr(enc_r(rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_SLTU, 5'd16, 5'd0, 5'd8));
    send_instr(enc_r(rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_XOR,  5'd17, 5'd1, 5'd2));
    send_instr(enc_r(rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_SR,   5'd18, 5'd8, 5'd5));
    send_instr(enc_r(rv32ss_pkg::F7_ALT,  rv32ss_pkg::F3_SR,   5'd19, 5'd8, 5'd5));
    send_instr(enc_r(rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_OR,   5'd20, 5'd8, 5'd7));
    send_instr(enc_r(rv32ss_pkg::F7_BASE, rv32ss_pkg::F3_AND,  5'd21, 5'd1, 5'd6));
    send_instr(enc_r(F7_BAD,              rv32ss_pkg::F3_ADD,  5'd22, 5'd1, 5'd2));
  endtask

  task automatic test_memory_and_port();
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_ADD, 5'd23, 5'd0, 12'h500));
    send_instr(enc_i(rv32ss_pkg::OPC_OPIMM, rv32ss_pkg::F3_SLL, 5'd23, 5'd23, 12'd4));
    send_instr(enc_s(rv32ss_pkg::F3_BYTE, 5'd23, 5'd2, 12'h000));
    // a word store to the port address goes to memory
    send_instr(enc_s(rv32ss_pkg::F3_WORD, 5'd23, 5'd8, 12'h000));
    send_instr(enc_i(rv32ss_pkg::OPC_LOAD, rv32ss_pkg::F3_WORD, 5'd24, 5'd23, 12'h000));
    // word at the top of memory wraps to address zero
    send_instr(enc_s(rv32ss_pkg::F3_WORD, 5'd1, 5'd2, 12'hFFF));
    send_instr(enc_i(rv32ss_pkg::OPC_LOAD, rv32ss_pkg::F3_WORD, 5'd25, 5'd1, 12'hFFF));
    send_instr(enc_i(rv32ss_pkg::OPC_LOAD, rv32ss_pkg::F3_WORD, 5'd0, 5'd23, 12'h000));
  endtask

  task automatic test_control_and_unsupported();
    send_instr(enc_b(rv32ss_pkg::F3_BEQ, 5'd0, 5'd0, 13'd8));
    send_instr(enc_b(rv32ss_pkg::F3_BEQ, 5'd1, 5'd0, 13'h1000));
    send_instr(enc_j(5'd27, 21'h0FFFFE));
    send_instr(enc_j(5'd0, 21'h100000));
    send_instr(enc_b(F3_BNE, 5'd1, 5'd0, 13'd16));
    send_instr(enc_i(rv32ss_pkg::OPC_LOAD, F3_HALF, 5'd28, 5'd0, 12'h000));
    send_instr(enc_s(F3_HALF, 5'd0, 5'd1, 12'h000));
    send_instr(32'hFFFF_FFFF);
  endtask

  task automatic test_back_to_back();
    int n;
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    for (n = 0; n < 150; n++) send_instr(random_instr());
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  task automatic test_output_backpressure();
    int n;
    rx_hold_cycles = HOLD_CYCLES;
    for (n = 0; n < 40; n++) send_instr(random_instr());
  endtask

  task automatic test_random_programs();
    int pick;
    while (instr_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) run_store_load();
      else if (pick < 15) run_port_write();
      else send_instr(random_instr());
    end
  endtask

  // ---------------------------------------------------------------- result side
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = rx_no_idle ? 0 : $urandom_range(0, 4);
      if (rx_hold_cycles != 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    retire_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_retires.size() == 0) begin
        $display("%0t: unexpected item, expected none, got next_pc %h", $time,
                 out_ch.next_pc);
        mismatch_count++;
      end else begin
        want = pending_retires.pop_front();
        check_field("next_pc", want.next_pc, out_ch.next_pc);
        check_field("reg_write_enable", 32'(want.wen), 32'(out_ch.reg_write_enable));
        check_field("reg_write_index", 32'(want.widx), 32'(out_ch.reg_write_index));
        check_field("reg_write_value", want.wval, out_ch.reg_write_value);
        check_field("char_valid", 32'(want.char_valid), 32'(out_ch.char_valid));
        check_field("char_value", 32'(want.char_value), 32'(out_ch.char_value));
        check_field("halted", 32'(want.halted), 32'(out_ch.halted));
      end
    end
  end

  // reset plus the memory clearing pass stays well below the limit
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.instruction = '0;
    rst_n             = 1'b0;
    apply_reset();
    test_alu_immediate();
    test_alu_register();
    test_memory_and_port();
    test_control_and_unsupported();
    test_back_to_back();
    test_output_backpressure();
    test_random_programs();
    wait_drained();
    if (mismatch_count == 0 && pending_retires.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
